// ----- src/scar_pkg.sv -----
// Shared types and constants for the slot cache with idle-age replacement.
`default_nettype none
package scar_pkg;

  localparam int KEY_W      = 4;
  localparam int CFG_W      = 5;
  localparam int SLOT_OUT_W = 3;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch key, clear scan state
    logic step;       // examine one slot
    logic reply_err;  // emit rejection result
    logic commit;     // apply update, emit result
  } scar_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_bad;    // requested key rejected
    logic last;       // scan is on the final slot
  } scar_stat_t;

endpackage
`default_nettype wire

// ----- src/scar_ctrl.sv -----
// Controller FSM: sequences accept, rejection, slot scan and commit.
`default_nettype none
module scar_ctrl
  import scar_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire scar_stat_t stat,
  output scar_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  logic   busy_r;

  assign busy = busy_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && start;
    cmd.reply_err = (state_r == ST_ERR);
    cmd.step      = (state_r == ST_SCAN);
    cmd.commit    = (state_r == ST_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            busy_r  <= 1'b1;
            state_r <= stat.key_bad ? ST_ERR : ST_SCAN;
          end
        end
        ST_ERR: begin
          busy_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
        ST_SCAN: begin
          if (stat.last) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          busy_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
        default: begin
          busy_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/scar_dp.sv -----
// Datapath: slot tags, valid bits, idle ages, scan registers and result register.
`default_nettype none
module scar_dp
  import scar_pkg::*;
#(
  parameter int SLOTS    = 8,
  parameter int KEYS     = 16,
  parameter int AGE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [KEY_W-1:0]      in_group_key,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire scar_cmd_t             cmd,
  output scar_stat_t                 stat,
  output logic                       out_valid,
  output logic [SLOT_OUT_W-1:0]      out_slot,
  output logic                       out_hit,
  output logic                       out_evicted,
  output logic                       out_error
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic [CFG_W-1:0]    num_groups_r;
  logic [KEY_W-1:0]    tag_r   [SLOTS];
  logic                valid_r [SLOTS];
  logic [AGE_BITS-1:0] age_r   [SLOTS];

  logic [KEY_W-1:0]    key_r;
  logic [SLOT_W-1:0]   idx_r;
  logic                hit_found_r, free_found_r;
  logic [SLOT_W-1:0]   hit_idx_r, free_idx_r, best_idx_r;
  logic [AGE_BITS-1:0] best_age_r;

  logic                out_valid_r, out_hit_r, out_evicted_r, out_error_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  logic [AGE_BITS-1:0] cur_age;
  logic                cur_valid;
  logic [KEY_W-1:0]    cur_tag;
  logic [AGE_BITS-1:0] cur_age_inc;
  logic [SLOT_W-1:0]   chosen;
  logic [31:0]         chosen_ext;

  assign stat.key_bad = ({1'b0, in_group_key} >= num_groups_r) ||
                        (32'(in_group_key) >= 32'(KEYS));
  assign stat.last    = (idx_r == SLOT_W'(SLOTS - 1));

  assign cur_age     = age_r[idx_r];
  assign cur_valid   = valid_r[idx_r];
  assign cur_tag     = tag_r[idx_r];
  // compare ages as they will be after the miss increment
  assign cur_age_inc = (cur_age == AGE_MAX) ? cur_age : cur_age + AGE_BITS'(1);

  assign chosen     = hit_found_r ? hit_idx_r : (free_found_r ? free_idx_r : best_idx_r);
  assign chosen_ext = 32'(chosen);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_groups_r <= '0;
    end else if (cfg_we) begin
      num_groups_r <= cfg_wdata;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r        <= in_group_key;
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
      best_idx_r   <= '0;
      best_age_r   <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + SLOT_W'(1);
      if (cur_valid && cur_tag == key_r && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= idx_r;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (idx_r == '0 || cur_age_inc > best_age_r) begin
        best_age_r <= cur_age_inc;
        best_idx_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_found_r) begin
      tag_r[chosen] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i] <= 1'b0;
        age_r[i]   <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (SLOT_W'(i) == chosen) begin
          age_r[i]   <= '0;
          valid_r[i] <= 1'b1;
        end else if (!hit_found_r && valid_r[i] && age_r[i] != AGE_MAX) begin
          age_r[i] <= age_r[i] + AGE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit || cmd.reply_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_err) begin
      out_slot_r    <= '0;
      out_hit_r     <= 1'b0;
      out_evicted_r <= 1'b0;
      out_error_r   <= 1'b1;
    end else if (cmd.commit) begin
      out_slot_r    <= chosen_ext[SLOT_OUT_W-1:0];
      out_hit_r     <= hit_found_r;
      out_evicted_r <= !hit_found_r && !free_found_r;
      out_error_r   <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_slot    = out_slot_r;
  assign out_hit     = out_hit_r;
  assign out_evicted = out_evicted_r;
  assign out_error   = out_error_r;

endmodule
`default_nettype wire

// ----- src/slot_cache_idle_age_replacement.sv -----
// Top level: slot cache with idle-age replacement.
// A rejected key goes from the error state to the result register; any other key goes
// through the slot scan, one slot per cycle, then the commit state and the result register.
// Requests are served one at a time; busy is high while a request is served.
// Results show for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties all slots, clears ages and the group count.
`default_nettype none
module slot_cache_idle_age_replacement
  import scar_pkg::*;
#(
  parameter int SLOTS    = 8,
  parameter int KEYS     = 16,
  parameter int AGE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [KEY_W-1:0]      in_group_key,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  output logic                       out_valid,
  output logic [SLOT_OUT_W-1:0]      out_slot,
  output logic                       out_hit,
  output logic                       out_evicted,
  output logic                       out_error
);

  scar_cmd_t  cmd;
  scar_stat_t stat;

  scar_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  scar_dp #(
    .SLOTS    (SLOTS),
    .KEYS     (KEYS),
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_group_key (in_group_key),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_slot     (out_slot),
    .out_hit      (out_hit),
    .out_evicted  (out_evicted),
    .out_error    (out_error)
  );

endmodule
`default_nettype wire

// ----- dv/cache_checker.sv -----
// Checker for the slot cache: predicts each request and compares the result transfers.
`timescale 1ns / 100ps
module cache_checker
  import scar_pkg::*;
#(
  parameter int SLOTS    = 8,
  parameter int KEYS     = 16,
  parameter int AGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [KEY_W-1:0]      in_group_key,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  out_valid,
  input  logic [SLOT_OUT_W-1:0] out_slot,
  input  logic                  out_hit,
  input  logic                  out_evicted,
  input  logic                  out_error,
  output int unsigned           mismatches,
  output int unsigned           pending_count
);

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic                  evicted;
    logic                  error;
  } lookup_t;

  logic [KEY_W-1:0]    slot_key [SLOTS];
  logic                slot_used [SLOTS];
  logic [AGE_BITS-1:0] slot_age [SLOTS];
  logic [CFG_W-1:0]    groups_limit;
  lookup_t             expected_lookups[$];

  initial begin
    mismatches    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    end
  endtask

  // Updates the cache image for one request and returns the answer it should get.
  function automatic lookup_t serve_request(input logic [KEY_W-1:0] key);
    lookup_t r;
    int      pick;
    bit      resident;
    bit      has_free;
    r        = '0;
    pick     = 0;
    resident = 1'b0;
    has_free = 1'b0;
    if (key >= groups_limit || key >= KEYS) begin
      r.error = 1'b1;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!resident && slot_used[i] && slot_key[i] == key) begin
        pick     = i;
        resident = 1'b1;
      end
    end
    if (resident) begin
      slot_age[pick] = '0;
      r.hit          = 1'b1;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!has_free && !slot_used[i]) begin
          pick     = i;
          has_free = 1'b1;
        end
      end
      if (!has_free) begin
        // strict compare keeps the lowest slot on a tie
        pick = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (slot_age[i] > slot_age[pick]) pick = i;
        end
        r.evicted = 1'b1;
      end
      slot_key[pick]  = key;
      slot_used[pick] = 1'b1;
      slot_age[pick]  = '0;
    end
    r.slot = pick[SLOT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    lookup_t want;
    if (!rst_n) begin
      expected_lookups.delete();
      groups_limit = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]  = '0;
        slot_used[i] = 1'b0;
        slot_age[i]  = '0;
      end
    end else begin
      if (cfg_we) groups_limit = cfg_wdata;
      if (start && !busy) expected_lookups.push_back(serve_request(in_group_key));
      if (out_valid) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result transfer with no request pending");
        end else begin
          want = expected_lookups.pop_front();
          check_field("slot", 8'(out_slot), 8'(want.slot));
          check_field("hit", 8'(out_hit), 8'(want.hit));
          check_field("evicted", 8'(out_evicted), 8'(want.evicted));
          check_field("error", 8'(out_error), 8'(want.error));
        end
      end
    end
    pending_count = expected_lookups.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the slot cache: request stimulus, group count setup and verdict.
`timescale 1ns / 100ps
module tb_top
  import scar_pkg::*;
();

  localparam int SLOTS    = 8;
  localparam int KEYS     = 16;
  localparam int AGE_BITS = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [KEY_W-1:0]      in_group_key;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  out_valid;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_hit;
  logic                  out_evicted;
  logic                  out_error;
  int unsigned           mismatches;
  int unsigned           pending_count;
  int                    idle_pct;
  int                    window_base;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  slot_cache_idle_age_replacement #(
    .SLOTS   (SLOTS),
    .KEYS    (KEYS),
    .AGE_BITS(AGE_BITS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_group_key(in_group_key),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_slot    (out_slot),
    .out_hit     (out_hit),
    .out_evicted (out_evicted),
    .out_error   (out_error)
  );

  cache_checker #(
    .SLOTS   (SLOTS),
    .KEYS    (KEYS),
    .AGE_BITS(AGE_BITS)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_group_key (in_group_key),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_slot     (out_slot),
    .out_hit      (out_hit),
    .out_evicted  (out_evicted),
    .out_error    (out_error),
    .mismatches   (mismatches),
    .pending_count(pending_count)
  );

  // Called just after a falling edge; returns just after the falling edge that follows the transfer.
  task automatic request(input logic [KEY_W-1:0] key);
    start        <= 1'b1;
    in_group_key <= key;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_groups(input logic [CFG_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a sliding window of ten keys so hits and evictions both show up often.
  function automatic logic [KEY_W-1:0] random_key(input int groups);
    int roll;
    int span;
    roll = $urandom_range(99);
    span = (groups > KEYS) ? KEYS : groups;
    if (span == 0 || roll >= 85) return KEY_W'($urandom_range(KEYS - 1));
    if (roll < 70) return KEY_W'((window_base + $urandom_range(9)) % span);
    return KEY_W'($urandom_range(span - 1));
  endfunction

  initial begin
    int phase_groups [9] = '{16, 11, 31, 4, 0, 16, 1, 8, 13};
    int phase_items  [9] = '{220, 180, 180, 170, 40, 220, 120, 200, 200};
    int sender_idle  [4] = '{0, 67, 0, 28};
    rst_n        = 1'b0;
    start        = 1'b0;
    in_group_key = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    idle_pct     = 0;
    window_base  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // group count is zero out of reset: everything is rejected
    request(KEY_W'(0));
    request(KEY_W'(15));
    drain();
    set_groups(CFG_W'(16));
    for (int k = 0; k < SLOTS; k++) request(KEY_W'(k));
    request(KEY_W'(3));
    request(KEY_W'(8));   // full: oldest slot goes
    request(KEY_W'(15));
    // hit every resident key so all ages tie at zero
    for (int k = 7; k >= 2; k--) request(KEY_W'(k));
    request(KEY_W'(15));
    request(KEY_W'(8));
    request(KEY_W'(9));   // tie on age: lowest slot replaced
    drain();
    set_groups(CFG_W'(5));
    request(KEY_W'(5));
    request(KEY_W'(4));

    for (int p = 0; p < 9; p++) begin
      drain();
      set_groups(CFG_W'(phase_groups[p]));
      idle_pct    = sender_idle[p % 4];
      window_base = $urandom_range(KEYS - 1);
      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(99) < idle_pct) pause_sender($urandom_range(1, 6));
        if ($urandom_range(199) == 0) drain();
        request(random_key(phase_groups[p]));
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/scar_pkg.sv
src/scar_ctrl.sv
src/scar_dp.sv
src/slot_cache_idle_age_replacement.sv
dv/cache_checker.sv
dv/tb_top.sv
